// ===== rtl/cdus_pkg.sv =====
// ----------------------------------------------------------------------------
// cdus_pkg
// Shared constants, stage payload types and the month offset table for the
// civil date to Unix seconds converter.
// ----------------------------------------------------------------------------
`default_nettype none

package cdus_pkg;

    localparam int YearW    = 12;
    localparam int MonthW   = 4;
    localparam int DayW     = 5;
    localparam int HourW    = 5;
    localparam int MinuteW  = 6;
    localparam int SecondW  = 6;
    localparam int SecondsW = 32;

    localparam int DoyW     = 9;
    localparam int TsecW    = 17;
    localparam int DaysW    = 21;
    localparam int Q100W    = 6;
    localparam int Q400W    = 4;
    localparam int RecipW   = 14;
    localparam int RecipSh  = 20;
    localparam int ProdW    = YearW + RecipW;
    localparam int ProdQW   = YearW - 2 + RecipW;

    localparam logic [YearW-1:0]   MinYear    = 12'd2000;
    localparam logic [MonthW-1:0]  MonthFirst = 4'd1;
    localparam logic [MonthW-1:0]  MonthFeb   = 4'd2;
    localparam logic [MonthW-1:0]  MonthLast  = 4'd12;
    localparam logic [DayW-1:0]    DayFirst   = 5'd1;
    localparam logic [DaysW-1:0]   YearDays   = 21'd365;
    localparam logic [DaysW-1:0]   EpochShift = 21'd719468;
    localparam logic [RecipW-1:0]  Recip100   = 14'd10486;
    localparam logic [TsecW-1:0]   SecsHour   = 17'd3600;
    localparam logic [TsecW-1:0]   SecsMin    = 17'd60;
    localparam logic [SecondsW-1:0] SecsDay   = 32'd86400;

    typedef struct packed {
        logic             ok;
        logic [YearW-1:0] yr;
        logic [DoyW-1:0]  doy;
        logic [TsecW-1:0] tsec;
    } prep_t;

    typedef struct packed {
        logic             ok;
        logic [DaysW-1:0] days_a;
        logic [Q100W-1:0] q100;
        logic [Q400W-1:0] q400;
        logic [TsecW-1:0] tsec;
    } ysum_t;

    typedef struct packed {
        logic             ok;
        logic [DaysW-1:0] days;
        logic [TsecW-1:0] tsec;
    } days_t;

    // Days from March 1 to the first day of the given month.
    function automatic logic [DoyW-1:0] month_offset(input logic [MonthW-1:0] month);
        logic [DoyW-1:0] off;
        case (month)
            4'd3:    off = 9'd0;
            4'd4:    off = 9'd31;
            4'd5:    off = 9'd61;
            4'd6:    off = 9'd92;
            4'd7:    off = 9'd122;
            4'd8:    off = 9'd153;
            4'd9:    off = 9'd184;
            4'd10:   off = 9'd214;
            4'd11:   off = 9'd245;
            4'd12:   off = 9'd275;
            4'd1:    off = 9'd306;
            4'd2:    off = 9'd337;
            default: off = 9'd0;
        endcase
        return off;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/cdus_prep.sv =====
// ----------------------------------------------------------------------------
// cdus_prep
// First stage: checks the date fields, shifts the year to a March-based
// year, looks up the day of year and folds the time of day into seconds.
// ----------------------------------------------------------------------------
`default_nettype none

module cdus_prep (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [cdus_pkg::YearW-1:0]    year,
    input  wire logic [cdus_pkg::MonthW-1:0]   month,
    input  wire logic [cdus_pkg::DayW-1:0]     day,
    input  wire logic [cdus_pkg::HourW-1:0]    hour,
    input  wire logic [cdus_pkg::MinuteW-1:0]  minute,
    input  wire logic [cdus_pkg::SecondW-1:0]  second,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output cdus_pkg::prep_t                    out_data
);

    logic            valid_reg, valid_next;
    cdus_pkg::prep_t data_reg, data_next;
    logic            early;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign early     = (month <= cdus_pkg::MonthFeb);

    always_comb begin
        valid_next = in_ready ? in_valid : valid_reg;
        data_next.ok = (year >= cdus_pkg::MinYear) && (month >= cdus_pkg::MonthFirst)
                    && (month <= cdus_pkg::MonthLast) && (day >= cdus_pkg::DayFirst);
        data_next.yr = year - cdus_pkg::YearW'(early);
        data_next.doy = cdus_pkg::month_offset(month) + cdus_pkg::DoyW'(day)
                      - cdus_pkg::DoyW'(1);
        data_next.tsec = cdus_pkg::TsecW'(hour) * cdus_pkg::SecsHour
                       + cdus_pkg::TsecW'(minute) * cdus_pkg::SecsMin
                       + cdus_pkg::TsecW'(second);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/cdus_days.sv =====
// ----------------------------------------------------------------------------
// cdus_days
// Two stages that turn the March-based year and day of year into days since
// the epoch: the year sum with century corrections, then the final offset.
// ----------------------------------------------------------------------------
`default_nettype none

module cdus_days (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire cdus_pkg::prep_t in_data,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output cdus_pkg::days_t      out_data
);

    logic            ysum_valid_reg, ysum_valid_next;
    cdus_pkg::ysum_t ysum_reg, ysum_next;
    logic            days_valid_reg, days_valid_next;
    cdus_pkg::days_t days_reg, days_next;
    logic            ysum_ready;
    logic [cdus_pkg::YearW-3:0]  yr_q;
    logic [cdus_pkg::ProdW-1:0]  prod100;
    logic [cdus_pkg::ProdQW-1:0] prod400;

    assign ysum_ready = !days_valid_reg || out_ready;
    assign in_ready   = !ysum_valid_reg || ysum_ready;
    assign out_valid  = days_valid_reg;
    assign out_data   = days_reg;

    always_comb begin
        yr_q    = in_data.yr[cdus_pkg::YearW-1:2];
        prod100 = cdus_pkg::ProdW'(in_data.yr) * cdus_pkg::ProdW'(cdus_pkg::Recip100);
        prod400 = cdus_pkg::ProdQW'(yr_q) * cdus_pkg::ProdQW'(cdus_pkg::Recip100);
        ysum_valid_next = in_ready ? in_valid : ysum_valid_reg;
        ysum_next.ok     = in_data.ok;
        ysum_next.days_a = cdus_pkg::DaysW'(in_data.yr) * cdus_pkg::YearDays
                         + cdus_pkg::DaysW'(yr_q) + cdus_pkg::DaysW'(in_data.doy);
        ysum_next.q100   = prod100[cdus_pkg::RecipSh +: cdus_pkg::Q100W];
        ysum_next.q400   = prod400[cdus_pkg::RecipSh +: cdus_pkg::Q400W];
        ysum_next.tsec   = in_data.tsec;
    end

    always_comb begin
        days_valid_next = ysum_ready ? ysum_valid_reg : days_valid_reg;
        days_next.ok    = ysum_reg.ok;
        days_next.days  = ysum_reg.days_a - cdus_pkg::DaysW'(ysum_reg.q100)
                        + cdus_pkg::DaysW'(ysum_reg.q400) - cdus_pkg::EpochShift;
        days_next.tsec  = ysum_reg.tsec;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ysum_valid_reg <= 1'b0;
            days_valid_reg <= 1'b0;
        end else begin
            ysum_valid_reg <= ysum_valid_next;
            days_valid_reg <= days_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            ysum_reg <= ysum_next;
        end
        if (ysum_valid_reg && ysum_ready) begin
            days_reg <= days_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/cdus_secs.sv =====
// ----------------------------------------------------------------------------
// cdus_secs
// Output stage: scales days to seconds, adds the time of day and zeroes the
// result of a rejected date.
// ----------------------------------------------------------------------------
`default_nettype none

module cdus_secs (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire cdus_pkg::days_t                 in_data,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [cdus_pkg::SecondsW-1:0]        out_seconds,
    output logic                                 out_ok
);

    logic                            valid_reg, valid_next;
    logic [cdus_pkg::SecondsW-1:0]   seconds_reg, seconds_next;
    logic                            ok_reg;
    logic [cdus_pkg::SecondsW-1:0]   total;

    assign in_ready    = !valid_reg || out_ready;
    assign out_valid   = valid_reg;
    assign out_seconds = seconds_reg;
    assign out_ok      = ok_reg;

    always_comb begin
        valid_next   = in_ready ? in_valid : valid_reg;
        total        = cdus_pkg::SecondsW'(in_data.days) * cdus_pkg::SecsDay
                     + cdus_pkg::SecondsW'(in_data.tsec);
        seconds_next = in_data.ok ? total : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            seconds_reg <= seconds_next;
            ok_reg      <= in_data.ok;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/civil_date_to_unix_seconds.sv =====
// ----------------------------------------------------------------------------
// civil_date_to_unix_seconds
// Requests pass the prep, year-sum, days and seconds registers in order,
// one request per cycle while m_tready is high. Each of the four stages
// holds one request and moves on when the stage after it is free or being
// emptied. Reset clears all stage valid bits; the pipeline comes up empty.
// ----------------------------------------------------------------------------
`default_nettype none

module civil_date_to_unix_seconds (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // year[11:0], month[15:12], day[20:16], hour[25:21], minute[31:26],
    // second[37:32], zero[39:38]
    input  wire logic [39:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // unix_seconds[31:0]
    output logic [31:0]      m_tdata,
    // valid_res[0]
    output logic [0:0]       m_tuser
);

    logic            prep_valid, prep_ready;
    cdus_pkg::prep_t prep_data;
    logic            days_valid, days_ready;
    cdus_pkg::days_t days_data;
    logic            res_ok;

    cdus_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .year      (s_tdata[11:0]),
        .month     (s_tdata[15:12]),
        .day       (s_tdata[20:16]),
        .hour      (s_tdata[25:21]),
        .minute    (s_tdata[31:26]),
        .second    (s_tdata[37:32]),
        .out_valid (prep_valid),
        .out_ready (prep_ready),
        .out_data  (prep_data)
    );

    cdus_days u_days (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (prep_valid),
        .in_ready  (prep_ready),
        .in_data   (prep_data),
        .out_valid (days_valid),
        .out_ready (days_ready),
        .out_data  (days_data)
    );

    cdus_secs u_secs (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (days_valid),
        .in_ready    (days_ready),
        .in_data     (days_data),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_seconds (m_tdata),
        .out_ok      (res_ok)
    );

    assign m_tuser = res_ok;

    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == 32'd0))
        else $error("Rejected date produced nonzero seconds.");

    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("Input stalled while the output stage is empty.");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("Output valid after reset.");

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stream testbench for the civil date to Unix seconds converter. A short
// table of directed dates runs first, with known timestamps typed in for
// epoch landmarks, the 32-bit wrap and rejected dates. Random dates follow,
// mostly well-formed and partly noise. Results without a typed-in timestamp
// are checked against a local day-count predictor, under random idling, a
// long receiver hold-off and one pause in which the pipeline drains.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NumRandom  = 1050;
    localparam int IdlePct    = 14;
    localparam int HoldCycles = 80;
    localparam int HoldAt     = 600;
    localparam int RxCalmLo   = 900;
    localparam int RxCalmHi   = 1100;
    localparam int TxCalmLo   = 300;
    localparam int TxCalmHi   = 500;
    localparam int PauseAt    = 800;
    localparam int TailCycles = 8;
    localparam int StallLimit = 2000;
    localparam int NumRows    = 21;

    typedef struct packed {
        logic [cdus_pkg::SecondW-1:0] second;
        logic [cdus_pkg::MinuteW-1:0] minute;
        logic [cdus_pkg::HourW-1:0]   hour;
        logic [cdus_pkg::DayW-1:0]    day;
        logic [cdus_pkg::MonthW-1:0]  month;
        logic [cdus_pkg::YearW-1:0]   year;
    } date_t;

    typedef struct packed {
        logic [cdus_pkg::SecondsW-1:0] secs;
        logic                          ok;
    } stamp_t;

    typedef struct packed {
        logic [cdus_pkg::YearW-1:0]    yr;
        logic [cdus_pkg::MonthW-1:0]   mo;
        logic [cdus_pkg::DayW-1:0]     dy;
        logic [cdus_pkg::HourW-1:0]    hh;
        logic [cdus_pkg::MinuteW-1:0]  mi;
        logic [cdus_pkg::SecondW-1:0]  ss;
        logic                          known;
        logic [cdus_pkg::SecondsW-1:0] secs;
        logic                          ok;
    } date_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [0:0]  m_tuser;

    stamp_t offered_stamp = '0;
    stamp_t stamps_due [$];
    int     errors = 0;
    int     requests = 0;
    int     rejected = 0;
    int     checked = 0;
    int     stall_cycles = 0;
    logic   tx_calm = 1'b0;

    date_row_t date_rows [NumRows] = '{
        '{12'd2000, 4'd1,  5'd1,  5'd0,  6'd0,  6'd0,  1'b1, 32'd946684800,  1'b1},
        '{12'd1999, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 1'b1, 32'd0,          1'b0},
        '{12'd0,    4'd0,  5'd0,  5'd0,  6'd0,  6'd0,  1'b1, 32'd0,          1'b0},
        '{12'd1970, 4'd1,  5'd1,  5'd0,  6'd0,  6'd0,  1'b1, 32'd0,          1'b0},
        '{12'd2000, 4'd0,  5'd1,  5'd0,  6'd0,  6'd0,  1'b1, 32'd0,          1'b0},
        '{12'd2000, 4'd13, 5'd1,  5'd0,  6'd0,  6'd0,  1'b1, 32'd0,          1'b0},
        '{12'd4095, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63, 1'b1, 32'd0,          1'b0},
        '{12'd2000, 4'd1,  5'd0,  5'd0,  6'd0,  6'd0,  1'b1, 32'd0,          1'b0},
        '{12'd2038, 4'd1,  5'd19, 5'd3,  6'd14, 6'd8,  1'b1, 32'd2147483648, 1'b1},
        '{12'd2106, 4'd2,  5'd7,  5'd6,  6'd28, 6'd15, 1'b1, 32'd4294967295, 1'b1},
        '{12'd2106, 4'd2,  5'd7,  5'd6,  6'd28, 6'd16, 1'b1, 32'd0,          1'b1},
        '{12'd2000, 4'd2,  5'd29, 5'd12, 6'd0,  6'd0,  1'b0, 32'd0,          1'b0},
        '{12'd2000, 4'd3,  5'd1,  5'd0,  6'd0,  6'd0,  1'b0, 32'd0,          1'b0},
        '{12'd2100, 4'd3,  5'd1,  5'd0,  6'd0,  6'd0,  1'b0, 32'd0,          1'b0},
        '{12'd2001, 4'd4,  5'd31, 5'd0,  6'd0,  6'd0,  1'b0, 32'd0,          1'b0},
        '{12'd2024, 4'd2,  5'd31, 5'd1,  6'd2,  6'd3,  1'b0, 32'd0,          1'b0},
        '{12'd2023, 4'd12, 5'd31, 5'd31, 6'd63, 6'd63, 1'b0, 32'd0,          1'b0},
        '{12'd2000, 4'd12, 5'd31, 5'd24, 6'd60, 6'd60, 1'b0, 32'd0,          1'b0},
        '{12'd4095, 4'd1,  5'd1,  5'd0,  6'd0,  6'd0,  1'b0, 32'd0,          1'b0},
        '{12'd4095, 4'd12, 5'd31, 5'd31, 6'd63, 6'd63, 1'b0, 32'd0,          1'b0},
        '{12'd2047, 4'd2,  5'd28, 5'd16, 6'd42, 6'd21, 1'b0, 32'd0,          1'b0}
    };

    civil_date_to_unix_seconds u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #10 aclk = ~aclk;

    // Days-from-civil count with March-based months, then seconds mod 2^32.
    function automatic stamp_t civil_to_stamp(input date_t d);
        stamp_t          r;
        longint unsigned yr, era, yoe, mp, doy, doe, days, total;
        r = '0;
        if (d.year < cdus_pkg::MinYear || d.month < cdus_pkg::MonthFirst ||
            d.month > cdus_pkg::MonthLast || d.day < cdus_pkg::DayFirst) begin
            return r;
        end
        yr    = longint'(d.year) - ((d.month <= cdus_pkg::MonthFeb) ? 1 : 0);
        era   = yr / 400;
        yoe   = yr - era * 400;
        mp    = (d.month > cdus_pkg::MonthFeb) ? longint'(d.month) - 3
                                               : longint'(d.month) + 9;
        doy   = (153 * mp + 2) / 5 + longint'(d.day) - 1;
        doe   = yoe * 365 + yoe / 4 - yoe / 100 + doy;
        days  = era * 146097 + doe - 719468;
        total = days * 86400 + longint'(d.hour) * 3600 + longint'(d.minute) * 60
              + longint'(d.second);
        r.secs = total[31:0];
        r.ok   = 1'b1;
        return r;
    endfunction

    task automatic offer(input date_t d, input stamp_t want);
        while (!tx_calm && $urandom_range(99) < IdlePct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid      <= 1'b1;
        s_tdata       <= {2'b00, d};
        offered_stamp <= want;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                stamps_due.push_back(offered_stamp);
                requests <= requests + 1;
                if (!offered_stamp.ok) begin
                    rejected <= rejected + 1;
                end
            end
            if (m_tvalid && m_tready) begin
                if (stamps_due.size() == 0) begin
                    $error("unexpected result: unix_seconds %0d valid_res %0d",
                           m_tdata, m_tuser);
                    errors = errors + 1;
                end else begin
                    stamp_t want;
                    want = stamps_due.pop_front();
                    checked <= checked + 1;
                    if (m_tdata !== want.secs) begin
                        $error("unix_seconds: expected %0d, actual %0d", want.secs, m_tdata);
                        errors = errors + 1;
                    end
                    if (m_tuser[0] !== want.ok) begin
                        $error("valid_res: expected %0d, actual %0d", want.ok, m_tuser[0]);
                        errors = errors + 1;
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= StallLimit) begin
                $display("CHECK FAILED");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    initial begin : rx_proc
        int cyc;
        cyc = 0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (cyc == HoldAt) begin
                m_tready <= 1'b0;
                repeat (HoldCycles) @(posedge aclk);
                cyc = cyc + HoldCycles;
            end else begin
                m_tready <= (cyc >= RxCalmLo && cyc < RxCalmHi) ||
                            ($urandom_range(99) >= IdlePct);
                @(posedge aclk);
                cyc = cyc + 1;
            end
        end
    end

    initial begin : tx_proc
        date_t     d;
        date_row_t r;
        stamp_t    want;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < NumRows; i++) begin
            r = date_rows[i];
            d.year   = r.yr;
            d.month  = r.mo;
            d.day    = r.dy;
            d.hour   = r.hh;
            d.minute = r.mi;
            d.second = r.ss;
            if (r.known) begin
                want.secs = r.secs;
                want.ok   = r.ok;
            end else begin
                want = civil_to_stamp(d);
            end
            offer(d, want);
        end

        for (int i = 0; i < NumRandom; i++) begin
            tx_calm <= (i >= TxCalmLo && i < TxCalmHi);
            if (i == PauseAt) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
                while (stamps_due.size() != 0) @(posedge aclk);
            end
            if ($urandom_range(99) < 80) begin
                d.year  = cdus_pkg::YearW'($urandom_range(4095, 2000));
                d.month = cdus_pkg::MonthW'($urandom_range(12, 1));
                d.day   = cdus_pkg::DayW'($urandom_range(31, 1));
            end else begin
                d.year  = cdus_pkg::YearW'($urandom_range(4095, 0));
                d.month = cdus_pkg::MonthW'($urandom_range(15, 0));
                d.day   = cdus_pkg::DayW'($urandom_range(31, 0));
            end
            d.hour   = cdus_pkg::HourW'($urandom_range(31, 0));
            d.minute = cdus_pkg::MinuteW'($urandom_range(63, 0));
            d.second = cdus_pkg::SecondW'($urandom_range(63, 0));
            offer(d, civil_to_stamp(d));
        end
        s_tvalid <= 1'b0;

        while (stamps_due.size() != 0) @(posedge aclk);
        repeat (TailCycles) @(posedge aclk);

        $display("Converted %0d dates, %0d of them rejected; %0d timestamps compared.",
                 requests, rejected, checked);
        $display("Stimulus covered leap days, the 32-bit wrap and unchecked time fields.");
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== civil_date_to_unix_seconds.f =====
rtl/cdus_pkg.sv
rtl/cdus_prep.sv
rtl/cdus_days.sv
rtl/cdus_secs.sv
rtl/civil_date_to_unix_seconds.sv
test/tb.sv
